@@ rtl/s3e_pkg.sv @@
// Shared types, constants and helpers for the 3x3 smallest-eigenvector solver.
`default_nettype none
package s3e_pkg;

	localparam int MAX_SWEEPS_DEF = 16;
	localparam int DIM            = 3;
	localparam int NUM_ENT        = 2 * DIM * DIM;
	localparam int ENT_W          = $clog2(NUM_ENT);
	localparam int V_BASE         = DIM * DIM;

	localparam logic [ENT_W-1:0] IDX_XX = ENT_W'(0);
	localparam logic [ENT_W-1:0] IDX_XY = ENT_W'(1);
	localparam logic [ENT_W-1:0] IDX_XZ = ENT_W'(2);
	localparam logic [ENT_W-1:0] IDX_YY = ENT_W'(4);
	localparam logic [ENT_W-1:0] IDX_YZ = ENT_W'(5);
	localparam logic [ENT_W-1:0] IDX_ZZ = ENT_W'(8);

	localparam logic signed [49:0] A_LIM   = 50'sd70368744177663;
	localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;
	localparam logic [63:0]        ONE_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [55:0]        RND_Q30 = 56'h0000_0000_2000_0000;

	typedef struct packed {
		logic signed [39:0] m_xx;
		logic signed [39:0] m_xy;
		logic signed [39:0] m_xz;
		logic signed [39:0] m_yy;
		logic signed [39:0] m_yz;
		logic signed [39:0] m_zz;
	} mat_t;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} ds_ctl_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} ds_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SWEEP, ST_PAIR, ST_RDP, ST_DIFF, ST_NORM, ST_SQ_A, ST_SQ_B,
		ST_HYP_GO, ST_HYP_W, ST_TT_GO, ST_TT_W, ST_TT_SQ, ST_R_GO, ST_R_W,
		ST_C_GO, ST_C_W, ST_MS, ST_MH, ST_ML, ST_MC, ST_MR, ST_ACC, ST_JX,
		ST_JY, ST_PICK, ST_OUT_RD, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_S, PH_COL, PH_ROW, PH_VEC
	} phase_t;

	function automatic logic [ENT_W-1:0] ent_idx(logic is_v, logic [1:0] r, logic [1:0] c);
		logic [ENT_W-1:0] base;
		base = is_v ? ENT_W'(V_BASE) : '0;
		return base + ENT_W'({r, 1'b0}) + ENT_W'(r) + ENT_W'(c);
	endfunction

	function automatic logic signed [47:0] sat_a(logic signed [49:0] x);
		if (x > A_LIM)
			return 48'(A_LIM);
		if (x < -A_LIM)
			return 48'(-A_LIM);
		return x[47:0];
	endfunction

	function automatic logic signed [31:0] sat_v(logic signed [47:0] x);
		if (x > ONE_Q30)
			return 32'(ONE_Q30);
		if (x < -ONE_Q30)
			return 32'(-ONE_Q30);
		return x[31:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/symmetric3_smallest_eigenvector.sv @@
// Top level: cyclic Jacobi solver returning the smallest eigenvector of a symmetric 3x3.
//
//   channel  dir  handshake              beat
//   mat      in   mat_valid/mat_ready    six upper-triangle entries, Q24.16
//   vec      out  vec_valid/vec_ready    eigenvector column, Q2.30
//
// One rotation uses two square roots and two divisions on the iterative divide/root unit
// and 37 rounded products on one multiplier.
// An item runs up to 3*MAX_SWEEPS rotations.
// mat_ready is high only between items; a held result on vec does not block the next beat.
// Reset clears the sequencer and vec_valid; the matrix store needs no clearing.
`default_nettype none
module symmetric3_smallest_eigenvector
	import s3e_pkg::*;
#(
	parameter int MAX_SWEEPS = MAX_SWEEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_ready,
	input  mat_t mat,
	output logic vec_valid,
	input  logic vec_ready,
	output vec_t vec
);

	localparam int SW_W = $clog2(MAX_SWEEPS + 1);

	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [SW_W-1:0]   sweep_q;
	logic [1:0]        pair_q, k_q, mi_q, best_q;
	logic signed [47:0] ent_q [NUM_ENT];
	logic signed [47:0] x_q, y_q;
	logic [46:0]       ud_q, ue_q;
	logic              tneg_q;
	logic [61:0]       p_q;
	logic [63:0]       sum_q;
	logic [32:0]       den_q;
	logic [30:0]       tt_q, r_q, c_q;
	logic signed [31:0] s_q;
	logic [46:0]       ux_q;
	logic [30:0]       uf_q;
	logic              mneg_q;
	logic [53:0]       hi_q;
	logic [25:0]       lo_q;
	logic signed [48:0] m_q, acc_q;
	vec_t              rv_q, vec_q;
	logic              vec_valid_q;

	ds_ctl_t           ds_ctl;
	ds_rsp_t           ds_rsp;
	logic [63:0]       ds_opn;
	logic [32:0]       ds_opd;

	logic [1:0]        p_idx, q_idx;
	logic [ENT_W-1:0]  rd_idx, xaddr, yaddr, wr_idx;
	logic signed [47:0] rd_val;
	logic              offdiag_zero, sweep_end, last_pair, last_k, norm_big, out_take;
	logic signed [48:0] d_full, e_full;
	logic [30:0]       mul_a, mul_b;
	logic [61:0]       prod;
	logic signed [47:0] mx_sel;
	logic signed [31:0] mf_sel;
	logic [47:0]       mx_abs;
	logic [31:0]       mf_abs;
	logic [55:0]       lo_sum;
	logic [48:0]       r_mag;
	logic signed [49:0] acc_sum;
	logic signed [47:0] min01;
	logic [1:0]        best_d;

	s3e_divsqrt u_ds (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ds_ctl),
		.opn    (ds_opn),
		.opd    (ds_opd),
		.rsp    (ds_rsp)
	);

	always_comb begin
		p_idx = (pair_q == 2'd2) ? 2'd1 : 2'd0;
		q_idx = (pair_q == 2'd0) ? 2'd1 : 2'd2;
		case (phase_q)
			PH_ROW: begin
				xaddr = ent_idx(1'b0, p_idx, k_q);
				yaddr = ent_idx(1'b0, q_idx, k_q);
			end
			PH_VEC: begin
				xaddr = ent_idx(1'b1, k_q, p_idx);
				yaddr = ent_idx(1'b1, k_q, q_idx);
			end
			default: begin
				xaddr = ent_idx(1'b0, k_q, p_idx);
				yaddr = ent_idx(1'b0, k_q, q_idx);
			end
		endcase
		case (state_q)
			ST_PAIR:   rd_idx = ent_idx(1'b0, p_idx, q_idx);
			ST_RDP:    rd_idx = ent_idx(1'b0, p_idx, p_idx);
			ST_DIFF:   rd_idx = ent_idx(1'b0, q_idx, q_idx);
			ST_JX:     rd_idx = xaddr;
			ST_JY:     rd_idx = yaddr;
			ST_OUT_RD: rd_idx = ent_idx(1'b1, k_q, best_q);
			default:   rd_idx = '0;
		endcase
		rd_val = ent_q[rd_idx];
		wr_idx = mi_q[1] ? yaddr : xaddr;

		offdiag_zero = (ent_q[IDX_XY] == '0) && (ent_q[IDX_XZ] == '0)
			&& (ent_q[IDX_YZ] == '0);
		sweep_end = (sweep_q == SW_W'(MAX_SWEEPS)) || offdiag_zero;
		last_pair = pair_q == 2'd2;
		last_k    = k_q == 2'd2;
		norm_big  = |{ud_q[46:31], ue_q[46:31]};
		out_take  = !vec_valid_q || vec_ready;

		d_full = {rd_val[47], rd_val} - {x_q[47], x_q};
		e_full = {y_q, 1'b0};

		mx_sel = mi_q[0] ? y_q : x_q;
		mf_sel = (mi_q[0] ^ mi_q[1]) ? s_q : $signed({1'b0, c_q});
		mx_abs = mx_sel[47] ? 48'(-mx_sel) : 48'(mx_sel);
		mf_abs = mf_sel[31] ? 32'(-mf_sel) : 32'(mf_sel);

		lo_sum  = {26'b0, hi_q[5:0], 24'b0} + {1'b0, p_q[54:0]} + RND_Q30;
		r_mag   = {1'b0, hi_q[53:6]} + {23'b0, lo_q};
		acc_sum = mi_q[1] ? ({acc_q[48], acc_q} + {m_q[48], m_q})
			: ({acc_q[48], acc_q} - {m_q[48], m_q});

		min01  = (ent_q[IDX_YY] < ent_q[IDX_XX]) ? ent_q[IDX_YY] : ent_q[IDX_XX];
		best_d = (ent_q[IDX_ZZ] < min01) ? 2'd2
			: ((ent_q[IDX_YY] < ent_q[IDX_XX]) ? 2'd1 : 2'd0);

		case (state_q)
			ST_SQ_A:  begin mul_a = ud_q[30:0];            mul_b = ud_q[30:0]; end
			ST_SQ_B:  begin mul_a = ue_q[30:0];            mul_b = ue_q[30:0]; end
			ST_TT_SQ: begin mul_a = tt_q;                  mul_b = tt_q;       end
			ST_MH:    begin mul_a = {8'b0, ux_q[46:24]};   mul_b = uf_q;       end
			ST_ML:    begin mul_a = {7'b0, ux_q[23:0]};    mul_b = uf_q;       end
			default:  begin mul_a = '0;                    mul_b = '0;         end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		state_d       = state_q;
		ds_ctl.start  = 1'b0;
		ds_ctl.sqrt   = 1'b0;
		ds_opn        = '0;
		ds_opd        = '0;
		case (state_q)
			ST_IDLE:   if (mat_valid) state_d = ST_SWEEP;
			ST_SWEEP:  state_d = sweep_end ? ST_PICK : ST_PAIR;
			ST_PAIR: begin
				if (rd_val != '0)
					state_d = ST_RDP;
				else
					state_d = last_pair ? ST_SWEEP : ST_PAIR;
			end
			ST_RDP:    state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_NORM;
			ST_NORM:   state_d = norm_big ? ST_NORM : ST_SQ_A;
			ST_SQ_A:   state_d = ST_SQ_B;
			ST_SQ_B:   state_d = ST_HYP_GO;
			ST_HYP_GO: begin
				ds_ctl.start = 1'b1;
				ds_ctl.sqrt  = 1'b1;
				ds_opn       = {2'b00, p_q} + sum_q;
				state_d      = ST_HYP_W;
			end
			ST_HYP_W:  if (ds_rsp.done) state_d = ST_TT_GO;
			ST_TT_GO: begin
				ds_ctl.start = 1'b1;
				ds_opn       = {3'b0, ue_q[30:0], 30'b0} + {32'b0, den_q[32:1]};
				ds_opd       = den_q;
				state_d      = ST_TT_W;
			end
			ST_TT_W:   if (ds_rsp.done) state_d = ST_TT_SQ;
			ST_TT_SQ:  state_d = ST_R_GO;
			ST_R_GO: begin
				ds_ctl.start = 1'b1;
				ds_ctl.sqrt  = 1'b1;
				ds_opn       = {2'b00, p_q} + ONE_Q60;
				state_d      = ST_R_W;
			end
			ST_R_W:    if (ds_rsp.done) state_d = ST_C_GO;
			ST_C_GO: begin
				ds_ctl.start = 1'b1;
				ds_opn       = ONE_Q60 + {34'b0, r_q[30:1]};
				ds_opd       = {2'b00, r_q};
				state_d      = ST_C_W;
			end
			ST_C_W:    if (ds_rsp.done) state_d = ST_MS;
			ST_MS:     state_d = ST_MH;
			ST_MH:     state_d = ST_ML;
			ST_ML:     state_d = ST_MC;
			ST_MC:     state_d = ST_MR;
			ST_MR:     state_d = ST_ACC;
			ST_ACC: begin
				if (phase_q == PH_S)
					state_d = ST_JX;
				else if (mi_q != 2'd3)
					state_d = ST_MS;
				else if (!last_k || phase_q != PH_VEC)
					state_d = ST_JX;
				else
					state_d = last_pair ? ST_SWEEP : ST_PAIR;
			end
			ST_JX:     state_d = ST_JY;
			ST_JY:     state_d = ST_MS;
			ST_PICK:   state_d = ST_OUT_RD;
			ST_OUT_RD: if (last_k) state_d = ST_DONE;
			ST_DONE:   if (out_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_S;
			sweep_q     <= '0;
			pair_q      <= '0;
			k_q         <= '0;
			mi_q        <= '0;
			best_q      <= '0;
			vec_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_take)
				vec_valid_q <= 1'b1;
			else if (vec_ready)
				vec_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (mat_valid) sweep_q <= '0;
				ST_SWEEP: begin
					pair_q <= '0;
					k_q    <= '0;
				end
				ST_PAIR: begin
					if (rd_val == '0) begin
						if (last_pair)
							sweep_q <= sweep_q + SW_W'(1);
						else
							pair_q <= pair_q + 2'd1;
					end
				end
				ST_C_W:   if (ds_rsp.done) phase_q <= PH_S;
				ST_ACC: begin
					if (phase_q == PH_S) begin
						phase_q <= PH_COL;
						k_q     <= '0;
					end else if (mi_q != 2'd3) begin
						mi_q <= mi_q + 2'd1;
					end else begin
						mi_q <= '0;
						if (!last_k) begin
							k_q <= k_q + 2'd1;
						end else begin
							k_q <= '0;
							case (phase_q)
								PH_COL: phase_q <= PH_ROW;
								PH_ROW: phase_q <= PH_VEC;
								default: begin
									if (last_pair)
										sweep_q <= sweep_q + SW_W'(1);
									else
										pair_q <= pair_q + 2'd1;
								end
							endcase
						end
					end
				end
				ST_JY:    mi_q <= '0;
				ST_PICK: begin
					best_q <= best_d;
					k_q    <= '0;
				end
				ST_OUT_RD: k_q <= k_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= prod;
		case (state_q)
			ST_IDLE: begin
				if (mat_valid) begin
					ent_q[0]  <= {{8{mat.m_xx[39]}}, mat.m_xx};
					ent_q[1]  <= {{8{mat.m_xy[39]}}, mat.m_xy};
					ent_q[2]  <= {{8{mat.m_xz[39]}}, mat.m_xz};
					ent_q[3]  <= {{8{mat.m_xy[39]}}, mat.m_xy};
					ent_q[4]  <= {{8{mat.m_yy[39]}}, mat.m_yy};
					ent_q[5]  <= {{8{mat.m_yz[39]}}, mat.m_yz};
					ent_q[6]  <= {{8{mat.m_xz[39]}}, mat.m_xz};
					ent_q[7]  <= {{8{mat.m_yz[39]}}, mat.m_yz};
					ent_q[8]  <= {{8{mat.m_zz[39]}}, mat.m_zz};
					ent_q[9]  <= ONE_Q30;
					ent_q[10] <= '0;
					ent_q[11] <= '0;
					ent_q[12] <= '0;
					ent_q[13] <= ONE_Q30;
					ent_q[14] <= '0;
					ent_q[15] <= '0;
					ent_q[16] <= '0;
					ent_q[17] <= ONE_Q30;
				end
			end
			ST_PAIR: y_q <= rd_val;
			ST_RDP:  x_q <= rd_val;
			ST_DIFF: begin
				ud_q   <= d_full[48] ? 47'(-d_full) : 47'(d_full);
				ue_q   <= e_full[48] ? 47'(-e_full) : 47'(e_full);
				tneg_q <= (d_full != '0) && (d_full[48] != y_q[47]);
			end
			ST_NORM: begin
				if (norm_big) begin
					ud_q <= {1'b0, ud_q[46:1]};
					ue_q <= {1'b0, ue_q[46:1]};
				end
			end
			ST_SQ_B:  sum_q <= {2'b00, p_q};
			ST_HYP_W: if (ds_rsp.done) den_q <= {2'b00, ud_q[30:0]} + {1'b0, ds_rsp.res};
			ST_TT_W:  if (ds_rsp.done) tt_q <= ds_rsp.res[30:0];
			ST_R_W:   if (ds_rsp.done) r_q <= ds_rsp.res[30:0];
			ST_C_W:   if (ds_rsp.done) c_q <= ds_rsp.res[30:0];
			ST_MS: begin
				if (phase_q == PH_S) begin
					ux_q   <= {16'b0, tt_q};
					uf_q   <= c_q;
					mneg_q <= tneg_q;
				end else begin
					ux_q   <= mx_abs[46:0];
					uf_q   <= mf_abs[30:0];
					mneg_q <= mx_sel[47] ^ mf_sel[31];
				end
			end
			ST_ML: hi_q <= p_q[53:0];
			ST_MC: lo_q <= lo_sum[55:30];
			ST_MR: m_q  <= mneg_q ? -$signed(r_mag) : $signed(r_mag);
			ST_ACC: begin
				if (phase_q == PH_S)
					s_q <= m_q[31:0];
				else if (!mi_q[0])
					acc_q <= m_q;
				else
					ent_q[wr_idx] <= sat_a(acc_sum);
			end
			ST_JX: x_q <= rd_val;
			ST_JY: y_q <= rd_val;
			ST_OUT_RD: begin
				case (k_q)
					2'd0:    rv_q.vec_x <= sat_v(rd_val);
					2'd1:    rv_q.vec_y <= sat_v(rd_val);
					default: rv_q.vec_z <= sat_v(rd_val);
				endcase
			end
			ST_DONE: if (out_take) vec_q <= rv_q;
			default: ;
		endcase
	end

	assign mat_ready = state_q == ST_IDLE;
	assign vec_valid = vec_valid_q;
	assign vec       = vec_q;

`ifndef NO_ASSERTIONS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ds_rsp.done |-> (state_q == ST_HYP_W || state_q == ST_TT_W
			|| state_q == ST_R_W || state_q == ST_C_W))
		else $error("root/quotient finished outside a wait state");
	a_tt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TT_SQ) |-> (tt_q <= 31'(ONE_Q30)))
		else $error("tangent above one");
	a_c_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_JX) |-> (c_q != '0)) else $error("cosine is zero");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_valid && mat_ready) |=> (state_q == ST_SWEEP && sweep_q == '0))
		else $error("accepted beat did not start a solve");
`endif

endmodule
`default_nettype wire

@@ rtl/s3e_divsqrt.sv @@
// Iterative restoring divider and integer square root sharing one subtractor.
`default_nettype none
module s3e_divsqrt
	import s3e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ds_ctl_t     ctl,
	input  logic [63:0] opn,
	input  logic [32:0] opd,
	output ds_rsp_t     rsp
);

	logic        busy_q;
	logic        done_q;
	logic        sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] n_q;
	logic [34:0] rem_q;
	logic [31:0] acc_q;
	logic [32:0] d_q;
	logic [34:0] cand;
	logic [34:0] sub;
	logic [34:0] diff;
	logic        ge;

	always_comb begin
		cand = sqrt_q ? {rem_q[32:0], n_q[63:62]} : {rem_q[33:0], n_q[63]};
		sub  = sqrt_q ? {1'b0, acc_q, 2'b01} : {2'b00, d_q};
		ge   = cand >= sub;
		diff = cand - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.sqrt ? 6'd32 : 6'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			sqrt_q <= ctl.sqrt;
			d_q    <= opd;
			acc_q  <= '0;
			if (ctl.sqrt) begin
				rem_q <= '0;
				n_q   <= opn;
			end else begin
				rem_q <= {2'b00, opn[63:31]};
				n_q   <= {opn[30:0], 33'b0};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff : cand;
			acc_q <= {acc_q[30:0], ge};
			n_q   <= sqrt_q ? {n_q[61:0], 2'b00} : {n_q[62:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q) else $error("divsqrt started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divsqrt done held");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 6'd1 && !ctl.start) |=> (done_q && !busy_q))
		else $error("divsqrt did not finish");
`endif

endmodule
`default_nettype wire
